// ===== rtl/mcte_pkg.sv =====
// mcte_pkg: shared types and constants of the midi clock tempo estimator
// used by midi_clock_tempo_estimator_core and the testbench; no dependencies
`timescale 1ns / 1ps

package mcte_pkg;

    // ring geometry and tick resolution
    localparam int RING_DEPTH     = 32;
    localparam int TICKS_PER_BEAT = 24;

    // field widths fixed by the interface
    localparam int CMD_W    = 1;
    localparam int AMOUNT_W = 16;
    localparam int TEMPO_W  = 14;
    localparam int HELD_W   = 6;
    localparam int SR_W     = 17;
    localparam int STAMP_W  = 64;

    // derived widths
    localparam int ADDR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SPAN_W  = SR_W + CNT_W;
    localparam int PROD_W  = SR_W + CNT_W;
    localparam int NUM_W   = PROD_W + 10;
    localparam int DEN_W   = SPAN_W + 7;
    localparam int Q_W     = TEMPO_W;
    localparam int CMP_W   = DEN_W + Q_W;
    localparam int DIV_W   = DEN_W + 1 + Q_W;
    localparam int QCNT_W  = $clog2(Q_W);

    // arithmetic constants
    localparam int MIN_HELD          = 7;
    localparam int MIN_TENTHS        = 200;
    localparam int MAX_TENTHS        = 9990;
    localparam int TENTHS_PER_MINUTE = 600;
    localparam int SR_RESET          = 48000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PULSE   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [AMOUNT_W-1:0] sample_amount;
    } t_in_req;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo_tenths;
        logic [HELD_W-1:0]  held_ticks;
    } t_out_res;

endpackage

// ===== rtl/midi_clock_tempo_estimator_core.sv =====
// midi_clock_tempo_estimator_core: tempo estimate from midi clock pulses
// depends on mcte_pkg and mcte_ram (pulse stamp ring)
`timescale 1ns / 1ps

// usage
//   input channel: one request per valid/stall handshake; cmd selects a clock
//   pulse at sample_amount samples past the current position, or an advance
//   of the position by sample_amount samples
//   output channel: one result per request, carrying the current tempo in
//   tenths of bpm (0 when none) and the number of held pulse stamps
//   config: i_cfg_we/i_cfg_data write sample_rate; write only while idle
// handshake and state sequence
//   one request at a time; o_in_stall is high from acceptance until the
//   result is loaded into the output register
//   advance: S_ADV, then S_FIN; pulse with fewer than seven stamps held:
//   S_PUL, then S_FIN; other pulses: S_PUL, S_RD, S_MUL, S_CHK, the serial
//   divider in S_DIV (one quotient bit per cycle) when in range, then S_FIN
// reset
//   synchronous, active low; position, ring fill and tempo cleared,
//   sample_rate back to 48000; ring memory contents are not cleared
// stall
//   a finished result waits in the output register; while i_out_stall holds
//   it there the block stays in its finish state and takes no new request

module midi_clock_tempo_estimator_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  mcte_pkg::t_in_req         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output mcte_pkg::t_out_res        o_out_data,
    input  logic                      i_cfg_we,
    input  logic [mcte_pkg::SR_W-1:0] i_cfg_data
);

    // state codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUL  = 3'd1;  // ring restart check, stamp write
    localparam logic [2:0] S_ADV  = 3'd2;  // timeout check
    localparam logic [2:0] S_RD   = 3'd3;  // oldest stamp arrives, span
    localparam logic [2:0] S_MUL  = 3'd4;  // numerator and denominator
    localparam logic [2:0] S_CHK  = 3'd5;  // tempo range check
    localparam logic [2:0] S_DIV  = 3'd6;  // serial rounding divide
    localparam logic [2:0] S_FIN  = 3'd7;  // load output register

    localparam int ADDR_W = mcte_pkg::ADDR_W;
    localparam int CNT_W  = mcte_pkg::CNT_W;
    localparam int DIV_W  = mcte_pkg::DIV_W;
    localparam int CMP_W  = mcte_pkg::CMP_W;
    localparam int Q_W    = mcte_pkg::Q_W;

    logic [2:0]                         r_state, n_state;
    logic [mcte_pkg::SR_W-1:0]          r_sr, n_sr;
    logic [mcte_pkg::STAMP_W-1:0]       r_pos, n_pos;
    logic [mcte_pkg::STAMP_W-1:0]       r_now, n_now;
    logic [mcte_pkg::STAMP_W-1:0]       r_last, n_last;     // copy of newest stamp
    logic [ADDR_W-1:0]                  r_wslot, n_wslot;
    logic [CNT_W-1:0]                   r_count, n_count;
    logic [mcte_pkg::TEMPO_W-1:0]       r_tempo, n_tempo;
    logic [mcte_pkg::SPAN_W-1:0]        r_span, n_span;
    logic [mcte_pkg::PROD_W-1:0]        r_prod, n_prod;
    logic [mcte_pkg::NUM_W-1:0]         r_num, n_num;
    logic [mcte_pkg::DEN_W-1:0]         r_den, n_den;
    logic [DIV_W-1:0]                   r_rem, n_rem;
    logic [DIV_W-1:0]                   r_dvs, n_dvs;
    logic [Q_W-1:0]                     r_q, n_q;
    logic [mcte_pkg::QCNT_W-1:0]        r_bit, n_bit;
    logic                               r_out_valid, n_out_valid;
    mcte_pkg::t_out_res                 r_out_data, n_out_data;

    // ring memory ports
    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_raddr;
    logic [mcte_pkg::STAMP_W-1:0]       ram_rdata;

    // combinational helpers
    logic                               in_take;
    logic                               restart;
    logic                               timeout;
    logic [CNT_W-1:0]                   cnt_base;
    logic [CNT_W-1:0]                   wnext;
    logic [CNT_W-1:0]                   rslot;
    logic [CMP_W-1:0]                   num_x;
    logic [CMP_W-1:0]                   lo_bound;
    logic [CMP_W-1:0]                   hi_bound;
    logic [DIV_W:0]                     trial;

    assign in_take = i_in_valid && (r_state == S_IDLE);

    // pulse: restart the ring when time does not move forward or the gap is over a second
    assign restart = (r_count != '0) &&
                     ((r_now <= r_last) ||
                      ((r_now - r_last) > mcte_pkg::STAMP_W'(r_sr)));

    // advance: clock counts as stopped after a second without pulses
    assign timeout = (r_count != '0) &&
                     ((r_pos - r_last) > mcte_pkg::STAMP_W'(r_sr));

    assign num_x    = CMP_W'(r_num);
    assign lo_bound = CMP_W'(r_den) * CMP_W'(mcte_pkg::MIN_TENTHS);
    assign hi_bound = CMP_W'(r_den) * CMP_W'(mcte_pkg::MAX_TENTHS);
    assign trial    = {1'b0, r_rem} - {1'b0, r_dvs};

    always_comb begin
        n_state     = r_state;
        n_sr        = r_sr;
        n_pos       = r_pos;
        n_now       = r_now;
        n_last      = r_last;
        n_wslot     = r_wslot;
        n_count     = r_count;
        n_tempo     = r_tempo;
        n_span      = r_span;
        n_prod      = r_prod;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_q         = r_q;
        n_bit       = r_bit;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        cnt_base    = '0;
        wnext       = '0;
        rslot       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_sr = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_in_data.cmd == mcte_pkg::CMD_PULSE) begin
                        n_now   = r_pos + mcte_pkg::STAMP_W'(i_in_data.sample_amount);
                        n_state = S_PUL;
                    end else begin
                        n_pos   = r_pos + mcte_pkg::STAMP_W'(i_in_data.sample_amount);
                        n_state = S_ADV;
                    end
                end
            end
            S_PUL: begin
                cnt_base = restart ? '0 : r_count;
                n_count  = (cnt_base == CNT_W'(mcte_pkg::RING_DEPTH)) ?
                           cnt_base : cnt_base + CNT_W'(1);
                ram_we   = 1'b1;
                n_last   = r_now;
                n_wslot  = (r_wslot == ADDR_W'(mcte_pkg::RING_DEPTH - 1)) ?
                           '0 : r_wslot + ADDR_W'(1);
                // oldest held stamp sits n_count slots behind the next write slot
                wnext    = CNT_W'(n_wslot);
                if (wnext >= n_count) begin
                    rslot = wnext - n_count;
                end else begin
                    rslot = CNT_W'(mcte_pkg::RING_DEPTH) - (n_count - wnext);
                end
                n_state  = (n_count >= CNT_W'(mcte_pkg::MIN_HELD)) ? S_RD : S_FIN;
            end
            S_ADV: begin
                if (timeout) begin
                    n_count = '0;
                    n_tempo = '0;
                end
                n_state = S_FIN;
            end
            S_RD: begin
                // span stays below 2^SPAN_W, so the low bits are enough
                n_span  = r_now[mcte_pkg::SPAN_W-1:0] -
                          ram_rdata[mcte_pkg::SPAN_W-1:0];
                n_prod  = mcte_pkg::PROD_W'(r_sr) *
                          mcte_pkg::PROD_W'(r_count - CNT_W'(1));
                n_state = S_MUL;
            end
            S_MUL: begin
                n_num   = mcte_pkg::NUM_W'(r_prod) *
                          mcte_pkg::NUM_W'(mcte_pkg::TENTHS_PER_MINUTE);
                n_den   = mcte_pkg::DEN_W'(r_span) *
                          mcte_pkg::DEN_W'(mcte_pkg::TICKS_PER_BEAT);
                n_state = S_CHK;
            end
            S_CHK: begin
                if ((num_x < lo_bound) || (num_x > hi_bound)) begin
                    n_state = S_FIN;
                end else begin
                    // round half up: (2*num + den) / (2*den)
                    n_rem   = DIV_W'({r_num, 1'b0}) + DIV_W'(r_den);
                    n_dvs   = DIV_W'(r_den) << Q_W;
                    n_q     = '0;
                    n_bit   = mcte_pkg::QCNT_W'(Q_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!trial[DIV_W]) begin
                    n_rem = trial[DIV_W-1:0];
                end
                n_q   = {r_q[Q_W-2:0], !trial[DIV_W]};
                n_dvs = r_dvs >> 1;
                if (r_bit == '0) begin
                    n_tempo = n_q;
                    n_state = S_FIN;
                end else begin
                    n_bit = r_bit - mcte_pkg::QCNT_W'(1);
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_data.tempo_tenths = r_tempo;
                    n_out_data.held_ticks   = mcte_pkg::HELD_W'(r_count);
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ram_raddr = rslot[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sr        <= mcte_pkg::SR_W'(mcte_pkg::SR_RESET);
            r_pos       <= '0;
            r_wslot     <= '0;
            r_count     <= '0;
            r_tempo     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sr        <= n_sr;
            r_pos       <= n_pos;
            r_wslot     <= n_wslot;
            r_count     <= n_count;
            r_tempo     <= n_tempo;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_last     <= n_last;
        r_span     <= n_span;
        r_prod     <= n_prod;
        r_num      <= n_num;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_q        <= n_q;
        r_bit      <= n_bit;
        r_out_data <= n_out_data;
    end

    // pulse stamp ring
    mcte_ram #(
        .WIDTH (mcte_pkg::STAMP_W),
        .DEPTH (mcte_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata (r_now),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ring fill never exceeds the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(mcte_pkg::RING_DEPTH))
        else $error("pulse count beyond ring depth");

    // an accepted pulse always leaves at least one stamp held
    a_pulse_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && (i_in_data.cmd == mcte_pkg::CMD_PULSE)) |=> ##1 (r_count != '0))
        else $error("pulse request left ring empty");

    // the divider only runs with enough stamps for an estimate
    a_div_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count >= CNT_W'(mcte_pkg::MIN_HELD)))
        else $error("divide started with too few stamps");

    // tempo is either cleared or inside the accepted range
    a_tempo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tempo == '0) ||
        ((r_tempo >= mcte_pkg::TEMPO_W'(mcte_pkg::MIN_TENTHS)) &&
         (r_tempo <= mcte_pkg::TEMPO_W'(mcte_pkg::MAX_TENTHS))))
        else $error("tempo estimate out of range");

endmodule

// ===== rtl/mcte_ram.sv =====
// mcte_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module mcte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb_midi_clock_tempo_estimator_core.sv =====
// tb_midi_clock_tempo_estimator_core: self-checking bench for the midi clock tempo estimator
// drives pulse and advance requests, predicts every result and compares them in order
// depends on mcte_pkg and midi_clock_tempo_estimator_core
`timescale 1ns / 1ps

module tb_midi_clock_tempo_estimator_core;

    // run limits
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;

    // clock, reset and block ports; the inputs are known from time zero
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    mcte_pkg::t_in_req           i_in_data   = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    mcte_pkg::t_out_res          o_out_data;
    logic                        i_cfg_we    = 1'b0;
    logic [mcte_pkg::SR_W-1:0]   i_cfg_data  = '0;

    // bench bookkeeping
    int          err_count   = 0;
    int          cycle_count = 0;
    int unsigned reqs_sent   = 0;
    int unsigned idle_pct    = 10;

    // results still owed by the block, oldest first
    mcte_pkg::t_out_res expected_results[$];

    // predicted block state: stamp ring, position, fill, estimate and sample rate
    logic [mcte_pkg::STAMP_W-1:0] stamp_ring [mcte_pkg::RING_DEPTH];
    logic [mcte_pkg::STAMP_W-1:0] position   = '0;
    logic [mcte_pkg::ADDR_W-1:0]  next_slot  = '0;
    logic [mcte_pkg::HELD_W-1:0]  held_count = '0;
    logic [mcte_pkg::TEMPO_W-1:0] tempo_now  = '0;
    logic [mcte_pkg::SR_W-1:0]    rate_cfg   = mcte_pkg::SR_W'(mcte_pkg::SR_RESET);

    midi_clock_tempo_estimator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // random back-pressure on the result channel
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // tempo predictor: applies one accepted request to the predicted state and
    // queues the result the block must return for it
    task automatic predict_tempo(input mcte_pkg::t_in_req req);
        logic [mcte_pkg::STAMP_W-1:0] stamp_now;
        logic [mcte_pkg::STAMP_W-1:0] last_stamp;
        logic [mcte_pkg::STAMP_W-1:0] span;
        logic [mcte_pkg::STAMP_W-1:0] num;
        logic [mcte_pkg::STAMP_W-1:0] den;
        mcte_pkg::t_out_res           res;
        if (req.cmd == mcte_pkg::CMD_PULSE) begin
            stamp_now = position + mcte_pkg::STAMP_W'(req.sample_amount);
            // time not moving forward or a gap over one second restarts the ring
            if (held_count != 0) begin
                last_stamp = stamp_ring[next_slot - mcte_pkg::ADDR_W'(1)];
                if (stamp_now <= last_stamp ||
                    stamp_now - last_stamp > mcte_pkg::STAMP_W'(rate_cfg))
                    held_count = '0;
            end
            stamp_ring[next_slot] = stamp_now;
            next_slot = next_slot + mcte_pkg::ADDR_W'(1);
            // fill saturates at the ring depth, oldest stamp is overwritten
            if (held_count < mcte_pkg::RING_DEPTH)
                held_count = held_count + mcte_pkg::HELD_W'(1);
            if (held_count >= mcte_pkg::MIN_HELD) begin
                // a full ring wraps the lookback to the slot about to be written
                span = stamp_now -
                       stamp_ring[next_slot - held_count[mcte_pkg::ADDR_W-1:0]];
                num  = 64'(mcte_pkg::TENTHS_PER_MINUTE) * 64'(rate_cfg) *
                       64'(held_count - mcte_pkg::HELD_W'(1));
                den  = 64'(mcte_pkg::TICKS_PER_BEAT) * span;
                // out-of-range tempo keeps the previous estimate
                if (span != 0 && num >= 64'(mcte_pkg::MIN_TENTHS) * den &&
                    num <= 64'(mcte_pkg::MAX_TENTHS) * den)
                    tempo_now = mcte_pkg::TEMPO_W'((2 * num + den) / (2 * den));
            end
        end else begin
            position = position + mcte_pkg::STAMP_W'(req.sample_amount);
            // clock timeout clears both the ring and the estimate
            if (held_count != 0) begin
                last_stamp = stamp_ring[next_slot - mcte_pkg::ADDR_W'(1)];
                if (position - last_stamp > mcte_pkg::STAMP_W'(rate_cfg)) begin
                    held_count = '0;
                    tempo_now  = '0;
                end
            end
        end
        res.tempo_tenths = tempo_now;
        res.held_ticks   = held_count;
        expected_results = {expected_results, res};
    endtask

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        mcte_pkg::t_out_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: tempo_tenths %0d held_ticks %0d",
                       o_out_data.tempo_tenths, o_out_data.held_ticks);
                err_count = err_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.tempo_tenths !== want.tempo_tenths) begin
                    $error("tempo_tenths mismatch: expected %0d actual %0d",
                           want.tempo_tenths, o_out_data.tempo_tenths);
                    err_count = err_count + 1;
                end
                if (o_out_data.held_ticks !== want.held_ticks) begin
                    $error("held_ticks mismatch: expected %0d actual %0d",
                           want.held_ticks, o_out_data.held_ticks);
                    err_count = err_count + 1;
                end
            end
        end
    end

    // one request through the valid/stall handshake; valid stays high afterwards
    // so back-to-back requests never drop it within a step
    task automatic send_req(input logic [mcte_pkg::CMD_W-1:0] cmd,
                            input logic [mcte_pkg::AMOUNT_W-1:0] amount);
        mcte_pkg::t_in_req req;
        req.cmd           = cmd;
        req.sample_amount = amount;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tempo(req);
        reqs_sent = reqs_sent + 1;
    endtask

    // wait until every result is back and the block has settled
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sample rate write, only with the block idle
    task automatic set_sample_rate(input logic [mcte_pkg::SR_W-1:0] rate);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        rate_cfg = rate;
    endtask

    // reset state seen through an empty advance, then a first pulse at position zero
    task automatic test_reset_state();
        send_req(mcte_pkg::CMD_ADVANCE, '0);
        send_req(mcte_pkg::CMD_PULSE, '0);
    endtask

    // steady clock at 240 bpm: estimate appears with the seventh held stamp, the task's sixth pulse
    task automatic test_steady_clock();
        for (int k = 0; k < 8; k++)
            send_req(mcte_pkg::CMD_PULSE, mcte_pkg::AMOUNT_W'(1000 + 500 * k));
    endtask

    // backwards stamp keeps the estimate, timeout clears it, equal stamps restart
    task automatic test_clock_breaks();
        send_req(mcte_pkg::CMD_PULSE, mcte_pkg::AMOUNT_W'(100));
        send_req(mcte_pkg::CMD_ADVANCE, '1);
        send_req(mcte_pkg::CMD_PULSE, '1);
        send_req(mcte_pkg::CMD_PULSE, '1);
        send_req(mcte_pkg::CMD_ADVANCE, '0);
    endtask

    // pulses far too close together give no estimate
    task automatic test_too_fast();
        send_req(mcte_pkg::CMD_ADVANCE, '1);
        for (int k = 1; k <= 7; k++)
            send_req(mcte_pkg::CMD_PULSE, mcte_pkg::AMOUNT_W'(10 * k));
    endtask

    // random clock runs with offsets spread over blocks, broken by stray
    // pulses, stops and plain noise
    task automatic test_clock_runs(input int unsigned n_reqs);
        int unsigned target;
        int unsigned run_len;
        int unsigned gap;
        int unsigned gap_lo;
        int unsigned gap_hi;
        int unsigned off;
        int unsigned adv;
        int unsigned carry;
        target = reqs_sent + n_reqs;
        while (reqs_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                // mostly tempos inside 20..999 bpm, sometimes anywhere
                if ($urandom_range(0, 99) < 70) begin
                    gap_lo = rate_cfg / 390 + 1;
                    gap_hi = rate_cfg / 9 + 1;
                end else begin
                    gap_lo = 1;
                    gap_hi = rate_cfg / 5 + 2;
                end
                gap     = $urandom_range(gap_lo, gap_hi);
                run_len = $urandom_range(3, 45);
                carry   = 0;
                repeat (run_len) begin
                    // carry is what the last advance left short of the pulse
                    off = carry + gap + $urandom_range(0, 2) - 1;
                    if (off > 65535)
                        off = 65535;
                    send_req(mcte_pkg::CMD_PULSE, mcte_pkg::AMOUNT_W'(off));
                    if ($urandom_range(0, 99) < 5)
                        send_req(mcte_pkg::CMD_PULSE, mcte_pkg::AMOUNT_W'($urandom));
                    if ($urandom_range(0, 99) < 80) begin
                        adv = $urandom_range(off / 2, off);
                        send_req(mcte_pkg::CMD_ADVANCE, mcte_pkg::AMOUNT_W'(adv));
                        carry = off - adv;
                    end else begin
                        // several pulses inside one block
                        carry = off;
                    end
                end
                // stop the clock long enough for a timeout
                if ($urandom_range(0, 99) < 40)
                    repeat (rate_cfg / 65535 + 2) send_req(mcte_pkg::CMD_ADVANCE, '1);
            end else begin
                repeat ($urandom_range(1, 3))
                    send_req(mcte_pkg::CMD_W'($urandom_range(0, 1)),
                             mcte_pkg::AMOUNT_W'($urandom));
            end
        end
    endtask

    initial begin
        // hold the synchronous reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset sample rate
        test_reset_state();
        test_steady_clock();
        test_clock_breaks();
        test_too_fast();

        // random part across sample rates, extremes included
        set_sample_rate(mcte_pkg::SR_W'(44100));
        test_clock_runs(220);
        set_sample_rate(mcte_pkg::SR_W'(96000));
        idle_pct = 0;
        test_clock_runs(220);
        idle_pct = 10;
        set_sample_rate('1);
        test_clock_runs(200);
        set_sample_rate('0);
        test_clock_runs(120);
        set_sample_rate(mcte_pkg::SR_W'(mcte_pkg::SR_RESET));
        test_clock_runs(300);

        drain_block();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mcte_pkg.sv
rtl/mcte_ram.sv
rtl/midi_clock_tempo_estimator_core.sv
tb/tb_midi_clock_tempo_estimator_core.sv
